FILE: hw/rtl/lpht_pkg.sv
// lpht_pkg: shared constants and types for the linear probe hash table
// no dependencies; imported by linear_probe_hash_table
`default_nettype none

package lpht_pkg;

	localparam int TABLE_SLOTS = 16;
	localparam int SLOT_W      = $clog2(TABLE_SLOTS);
	localparam int KEY_W       = 31;
	localparam int IDX_W       = 4;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_SEARCH = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_FOUND     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PROBE,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/linear_probe_hash_table.sv
// linear_probe_hash_table: open-addressed hash table with linear probing
// depends on lpht_pkg (constants, command, status and state types)
`default_nettype none

// One item is an insert or a search of a 31-bit key. The home slot is the
// key modulo TABLE_SLOTS (16, so the low key bits). A small sequencer walks
// the slots from the home slot, wrapping, one slot per clock through a
// single key comparator and a single read port on the key store. The item
// is taken in S_IDLE, then 1 to TABLE_SLOTS slots are probed (one per
// slot visited), then the result sits in the output register until taken;
// a full lap (16 probes) is the worst case. in_ready is high only while no
// item is in flight. The valid bits clear at reset, so the table starts
// empty with no clearing pass; key entries are only compared while valid.
// Inserts store duplicates again; a full table leaves the table unchanged
// and returns table full with slot_index zero, as does not found.
module linear_probe_hash_table
	import lpht_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             cmd,
	input  wire logic [KEY_W-1:0] key,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            status,
	output logic [IDX_W-1:0]      slot_index
);

	// sequencer state
	state_t              state_q, state_d;
	cmd_t                cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [SLOT_W-1:0]   ptr_q;     // slot being probed
	logic [SLOT_W-1:0]   cnt_q;     // probes done so far in this lap
	status_t             status_q;
	logic [IDX_W-1:0]    idx_q;

	// table storage: keys without reset, valid bits cleared at reset
	logic [KEY_W-1:0]    slot_keys [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] slot_valid_q;

	// key store read port, fetched at the edge that moves the pointer
	logic [SLOT_W-1:0]   rd_addr;
	logic [KEY_W-1:0]    rd_key_q;

	// control from the sequencer
	logic                take_in;
	logic                wr_en;
	logic                res_en;
	status_t             res_status;
	logic                advance;

	// probe datapath: one read, one compare
	logic                cur_valid;
	logic                cur_match;
	logic [SLOT_W-1:0]   ptr_next;
	logic [SLOT_W-1:0]   home_slot;

	assign cur_valid = slot_valid_q[ptr_q];
	assign cur_match = (rd_key_q == key_q);
	assign ptr_next  = (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
	assign home_slot = SLOT_W'(key % TABLE_SLOTS);

	// address the pointer takes at the next edge, so the key register
	// always holds the entry under ptr_q while probing
	assign rd_addr   = take_in ? home_slot : (advance ? ptr_next : ptr_q);

	// next state and control
	always_comb begin
		state_d    = state_q;
		take_in    = 1'b0;
		wr_en      = 1'b0;
		res_en     = 1'b0;
		res_status = ST_NOT_FOUND;
		advance    = 1'b0;
		in_ready   = 1'b0;
		out_valid  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					take_in = 1'b1;
					state_d = S_PROBE;
				end
			end
			S_PROBE: begin
				if (cmd_q == CMD_INSERT) begin
					if (!cur_valid) begin
						// empty slot: claim it
						wr_en      = 1'b1;
						res_en     = 1'b1;
						res_status = ST_INSERTED;
					end else if (cnt_q == LAST_SLOT) begin
						// whole lap without an empty slot
						res_en     = 1'b1;
						res_status = ST_FULL;
					end else begin
						advance = 1'b1;
					end
				end else begin
					if (!cur_valid) begin
						// empty slot ends the chain
						res_en     = 1'b1;
						res_status = ST_NOT_FOUND;
					end else if (cur_match) begin
						res_en     = 1'b1;
						res_status = ST_FOUND;
					end else if (cnt_q == LAST_SLOT) begin
						res_en     = 1'b1;
						res_status = ST_NOT_FOUND;
					end else begin
						advance = 1'b1;
					end
				end
				if (res_en) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (wr_en) begin
			slot_valid_q[ptr_q] <= 1'b1;
		end
	end

	// key store, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_keys[ptr_q] <= key_q;
		end
		rd_key_q <= slot_keys[rd_addr];
	end

	// item registers, probe pointer and lap counter
	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_q <= cmd_t'(cmd);
			key_q <= key;
			ptr_q <= home_slot;
			cnt_q <= '0;
		end else if (advance) begin
			ptr_q <= ptr_next;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// result register; index is zero unless a slot was written or matched
	always_ff @(posedge clk) begin
		if (res_en) begin
			status_q <= res_status;
			if (res_status == ST_INSERTED || res_status == ST_FOUND) begin
				idx_q <= IDX_W'(ptr_q);
			end else begin
				idx_q <= '0;
			end
		end
	end

	assign status     = status_q;
	assign slot_index = idx_q;

endmodule

`default_nettype wire
